[rtl/ecd_pkg.sv]
package ecd_pkg;

	localparam int OFFSET_W = 17;

	localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [6:0]  EPOCH_YEAR_100 = 7'd70;
	localparam logic [1:0]  EPOCH_CENT_4   = 2'd3;
	localparam logic [3:0]  LAST_MONTH     = 4'd12;

	// Restoring division: the divisor starts shifted up so that the
	// quotient fits in the number of steps.
	localparam int DAY_STEPS  = 16;
	localparam int HOUR_STEPS = 5;
	localparam int MIN_STEPS  = 6;
	localparam logic [31:0] DAY_DIV_TOP  = 32'(64'd86400 << (DAY_STEPS - 1));
	localparam logic [31:0] HOUR_DIV_TOP = 32'(64'd3600 << (HOUR_STEPS - 1));
	localparam logic [31:0] MIN_DIV_TOP  = 32'(64'd60 << (MIN_STEPS - 1));

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic        use_local;
	} in_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} out_t;

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

[rtl/epoch_seconds_to_calendar_date.sv]
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into a Gregorian date and
// time of day, optionally shifted by the signed UTC offset register (a zero count always
// gives the epoch). All arithmetic runs through one shared 32-bit subtract-and-compare
// unit under a small sequencer: 16 steps of restoring division by 86400, one step per
// elapsed year plus one, one step per elapsed month plus one, then 5 and 6 division steps
// for hour and minute, and a done state that loads the output register. A new request is
// accepted in the cycle after the previous result has moved into the output register, so
// a stalled output holds the block until it drains.
module epoch_seconds_to_calendar_date
	import ecd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  in_t                        in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output out_t                       out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic signed [OFFSET_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DAY   = 3'd1;
	localparam logic [2:0] ST_YEAR  = 3'd2;
	localparam logic [2:0] ST_MONTH = 3'd3;
	localparam logic [2:0] ST_HOUR  = 3'd4;
	localparam logic [2:0] ST_MIN   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                 state_q;
	logic signed [OFFSET_W-1:0] offset_q;
	logic [31:0]                acc_q;
	logic [31:0]                div_q;
	logic [3:0]                 cnt_q;
	logic [15:0]                days_q;
	logic [11:0]                year_q;
	logic [6:0]                 year100_q;
	logic [1:0]                 cent4_q;
	logic [3:0]                 month_q;
	logic [4:0]                 hour_q;
	logic [5:0]                 minute_q;
	logic                       out_valid_q;
	out_t                       out_q;

	logic        in_take;
	logic        out_load;
	logic        leap;
	logic [31:0] start_t;
	logic [31:0] opa;
	logic [31:0] opb;
	logic [32:0] diff;
	logic        ge;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign leap = (year_q[1:0] == 2'd0) && ((year100_q != 7'd0) || (cent4_q == 2'd0));

	always_comb begin
		start_t = in_data.epoch_seconds;
		if (in_data.use_local && (in_data.epoch_seconds != 32'd0)) begin
			start_t = in_data.epoch_seconds + 32'(offset_q);
		end
	end

	always_comb begin
		opa = acc_q;
		opb = div_q;
		case (state_q)
			ST_YEAR: begin
				opa = {16'd0, days_q};
				opb = {23'd0, year_len(leap)};
			end
			ST_MONTH: begin
				opa = {16'd0, days_q};
				opb = {27'd0, month_len(month_q, leap)};
			end
			default: begin
				opa = acc_q;
				opb = div_q;
			end
		endcase
	end

	assign diff = {1'b0, opa} - {1'b0, opb};
	assign ge   = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_DAY;
					end
				end
				ST_DAY: begin
					if (cnt_q == 4'd0) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!ge) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (!ge || (month_q == LAST_MONTH)) begin
						state_q <= ST_HOUR;
					end
				end
				ST_HOUR: begin
					if (cnt_q == 4'd0) begin
						state_q <= ST_MIN;
					end
				end
				ST_MIN: begin
					if (cnt_q == 4'd0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q  <= start_t;
				div_q  <= DAY_DIV_TOP;
				cnt_q  <= 4'(DAY_STEPS - 1);
				days_q <= '0;
			end
			ST_DAY: begin
				if (ge) begin
					acc_q <= diff[31:0];
				end
				days_q <= {days_q[14:0], ge};
				div_q  <= div_q >> 1;
				cnt_q  <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					year_q    <= EPOCH_YEAR;
					year100_q <= EPOCH_YEAR_100;
					cent4_q   <= EPOCH_CENT_4;
				end
			end
			ST_YEAR: begin
				if (ge) begin
					days_q <= diff[15:0];
					year_q <= year_q + 12'd1;
					if (year100_q == 7'd99) begin
						year100_q <= 7'd0;
						cent4_q   <= cent4_q + 2'd1;
					end else begin
						year100_q <= year100_q + 7'd1;
					end
				end else begin
					month_q <= 4'd1;
				end
			end
			ST_MONTH: begin
				if (ge && (month_q != LAST_MONTH)) begin
					days_q  <= diff[15:0];
					month_q <= month_q + 4'd1;
				end else begin
					div_q <= HOUR_DIV_TOP;
					cnt_q <= 4'(HOUR_STEPS - 1);
				end
			end
			ST_HOUR: begin
				if (ge) begin
					acc_q <= diff[31:0];
				end
				hour_q <= {hour_q[3:0], ge};
				if (cnt_q == 4'd0) begin
					div_q <= MIN_DIV_TOP;
					cnt_q <= 4'(MIN_STEPS - 1);
				end else begin
					div_q <= div_q >> 1;
					cnt_q <= cnt_q - 4'd1;
				end
			end
			ST_MIN: begin
				if (ge) begin
					acc_q <= diff[31:0];
				end
				minute_q <= {minute_q[4:0], ge};
				div_q    <= div_q >> 1;
				cnt_q    <= cnt_q - 4'd1;
			end
			default: begin
				if (out_load) begin
					out_q.year   <= year_q;
					out_q.month  <= month_q;
					out_q.day    <= days_q[4:0] + 5'd1;
					out_q.hour   <= hour_q;
					out_q.minute <= minute_q;
					out_q.second <= acc_q[5:0];
				end
			end
		endcase
	end

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_DAY))
		else $error("accepted request did not start the day division");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> ((year_q >= 12'd1970) && (year_q <= 12'd2106)))
		else $error("year counter left its range");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> ((month_q >= 4'd1) && (month_q <= LAST_MONTH)))
		else $error("month counter left its range");

	a_out_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.day != 5'd0) && (out_q.hour <= 5'd23)
			&& (out_q.minute <= 6'd59) && (out_q.second <= 6'd59)))
		else $error("result field out of range");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result presented outside the done state");

endmodule

[tb/epoch_seconds_to_calendar_date_tb.sv]
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_date_tb;
	import ecd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int SECS_PER_DAY   = 86400;

	class date_scoreboard;
		out_t                        expected_dates[$];
		logic signed [OFFSET_W-1:0]  offset;
		int                          mismatches;
		int                          requests_seen;
		int                          dates_checked;

		function new();
			offset = '0;
			mismatches = 0;
			requests_seen = 0;
			dates_checked = 0;
		endfunction

		function bit leap_year(int unsigned yr);
			return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		endfunction

		function out_t calendar_of(in_t req);
			logic [31:0] secs;
			int unsigned days;
			int unsigned rem;
			int unsigned yr;
			int unsigned mon;
			int unsigned ylen;
			int unsigned mlen;
			out_t date;
			secs = req.epoch_seconds;
			if (req.use_local && secs != 32'd0) begin
				secs = secs + {{(32 - OFFSET_W){offset[OFFSET_W-1]}}, offset};
			end
			days = secs / SECS_PER_DAY;
			rem = secs % SECS_PER_DAY;
			yr = 1970;
			forever begin
				ylen = leap_year(yr) ? 366 : 365;
				if (days < ylen) begin
					break;
				end
				days -= ylen;
				yr++;
			end
			mon = 1;
			forever begin
				case (mon)
					2: begin
						mlen = leap_year(yr) ? 29 : 28;
					end
					4, 6, 9, 11: begin
						mlen = 30;
					end
					default: begin
						mlen = 31;
					end
				endcase
				if (days < mlen || mon >= 12) begin
					break;
				end
				days -= mlen;
				mon++;
			end
			date.year = yr[11:0];
			date.month = mon[3:0];
			date.day = 5'(days + 1);
			date.hour = 5'(rem / 3600);
			date.minute = 6'((rem % 3600) / 60);
			date.second = 6'(rem % 60);
			return date;
		endfunction

		function void note_request(in_t req);
			expected_dates.push_back(calendar_of(req));
			requests_seen++;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_dates.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d", $time,
					got.year, got.month, got.day, got.hour, got.minute, got.second);
				return;
			end
			want = expected_dates.pop_front();
			dates_checked++;
			compare_field("year", want.year, got.year);
			compare_field("month", want.month, got.month);
			compare_field("day", want.day, got.day);
			compare_field("hour", want.hour, got.hour);
			compare_field("minute", want.minute, got.minute);
			compare_field("second", want.second, got.second);
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	in_t                        in_data;
	logic                       out_valid;
	logic                       out_stall;
	out_t                       out_data;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic signed [OFFSET_W-1:0] cfg_data;

	date_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_burst;
	int idle_cycles;
	int offsets_written;

	epoch_seconds_to_calendar_date u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
		if (stall_burst > 0) begin
			out_stall <= 1'b1;
			stall_burst--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic in_t req_of(logic [31:0] secs, logic in_local);
		in_t req;
		req.epoch_seconds = secs;
		req.use_local = in_local;
		return req;
	endfunction

	function automatic in_t random_request();
		in_t req;
		int unsigned pick;
		int unsigned yr;
		int unsigned days;
		pick = $urandom_range(99);
		yr = $urandom_range(2105, 1970);
		days = 0;
		for (int unsigned k = 1970; k < yr; k++) begin
			days += sb.leap_year(k) ? 366 : 365;
		end
		req.use_local = $urandom_range(1);
		if (pick < 35) begin
			req.epoch_seconds = $urandom();
		end else if (pick < 55) begin
			req.epoch_seconds = days * SECS_PER_DAY + $urandom_range(2 * SECS_PER_DAY)
				- SECS_PER_DAY;
		end else if (pick < 75) begin
			req.epoch_seconds = (days + 58 + $urandom_range(2)) * SECS_PER_DAY
				+ $urandom_range(SECS_PER_DAY - 1);
		end else if (pick < 85) begin
			req.epoch_seconds = (days + $urandom_range(364)) * SECS_PER_DAY
				+ ($urandom_range(1) ? SECS_PER_DAY - 1 : 0);
		end else if (pick < 92) begin
			req.epoch_seconds = $urandom_range(1) ? $urandom_range(200000)
				: 32'hFFFF_FFFF - $urandom_range(200000);
		end else begin
			req.use_local = 1'b1;
			req.epoch_seconds = 32'd0 - {{(32 - OFFSET_W){sb.offset[OFFSET_W-1]}}, sb.offset}
				+ $urandom_range(4) - 2;
		end
		return req;
	endfunction

	task automatic send_request(input in_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		sb.note_request(req);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_dates.size() != 0);
	endtask

	task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.offset = value;
		offsets_written++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) == 0) begin
				drain_results();
			end
			send_request(random_request());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 38;
		recv_idle_pct = 75;
		stall_burst = 0;
		idle_cycles = 0;
		offsets_written = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(req_of(32'd0, 1'b0));
		send_request(req_of(32'd0, 1'b1));
		send_request(req_of(32'hFFFF_FFFF, 1'b0));
		send_request(req_of(32'd86399, 1'b0));
		send_request(req_of(32'd86400, 1'b1));
		send_request(req_of(32'd31535999, 1'b0));
		send_request(req_of(32'd31536000, 1'b0));
		send_request(req_of(32'd68169599, 1'b0));
		send_request(req_of(32'd68169600, 1'b0));
		send_request(req_of(32'd946684799, 1'b0));
		send_request(req_of(32'd951782400, 1'b0));
		send_request(req_of(32'd951868800, 1'b0));
		send_request(req_of(32'd4107542399, 1'b0));
		send_request(req_of(32'd4107542400, 1'b0));
		send_request(req_of(32'hAAAA_AAAA, 1'b0));
		send_request(req_of(32'h5555_5555, 1'b1));

		write_offset(17'sd50400);
		send_request(req_of(32'd1, 1'b1));
		send_request(req_of(32'd0, 1'b1));
		send_request(req_of(32'hFFFF_FFFF, 1'b1));
		send_request(req_of(32'd86400, 1'b0));

		write_offset(-17'sd50400);
		send_request(req_of(32'd50400, 1'b1));
		send_request(req_of(32'd1, 1'b1));
		send_request(req_of(32'd50399, 1'b1));
		send_request(req_of(32'd0, 1'b1));

		write_offset(OFFSET_W'($urandom_range(100800) - 50400));
		run_random(300);
		write_offset(-17'sd65536);
		run_random(300);

		send_idle_pct = 75;
		recv_idle_pct = 38;
		write_offset(17'sd65535);
		run_random(300);
		write_offset(OFFSET_W'($urandom()));
		run_random(300);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_offset(-17'sd50400);
		// Hold the output long enough that the block backs up into its input.
		stall_burst = 400;
		run_random(300);
		write_offset(17'sd0);
		run_random(300);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_dates.size() != 0) begin
			sb.mismatches++;
			$display("%0t: %0d expected dates never arrived", $time, sb.expected_dates.size());
		end
		$display("Checked %0d of %0d conversions over %0d offset settings, both offset ends included.",
			sb.dates_checked, sb.requests_seen, offsets_written);
		$display("Traffic ran with sender/receiver idling at 38/75, 75/38 and 0/0 percent.");
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
